/* rtl/serial_acia_uart_top_defines.svh */
// Assertion helpers for the RTL files that carry checks.
`ifndef SERIAL_ACIA_UART_TOP_DEFINES_SVH
`define SERIAL_ACIA_UART_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sau_pkg.sv */
package sau_pkg;

    // Bus operation codes carried by a request beat
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_WR_CTRL   = 3'd1,
        OP_WR_TXDATA = 3'd2,
        OP_RD_STATUS = 3'd3,
        OP_RD_RXDATA = 3'd4
    } sau_op_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_DCD = 1'b0,
        CFG_CTS = 1'b1
    } sau_cfg_idx_t;

    // Serial frame phase, shared by transmitter and receiver
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DATA   = 2'd1,
        PH_PARITY = 2'd2,
        PH_STOP   = 2'd3
    } sau_phase_t;

    // Status register bit positions (bit 7 always reads zero)
    localparam int unsigned ST_RDRF = 0;
    localparam int unsigned ST_TDRE = 1;
    localparam int unsigned ST_DCD  = 2;
    localparam int unsigned ST_CTS  = 3;
    localparam int unsigned ST_FE   = 4;
    localparam int unsigned ST_OVRN = 5;
    localparam int unsigned ST_PE   = 6;

    // Control byte fields
    localparam logic [1:0] CTRL_MASTER_RESET = 2'b11;
    localparam logic [1:0] TXC_RTS_HIGH      = 2'b10;
    localparam logic [1:0] TXC_BREAK         = 2'b11;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       rx_bit;
    } sau_item_t;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] read_data;
        logic       rts_line;
    } sau_result_t;

    typedef struct packed {
        logic         en;
        sau_cfg_idx_t index;
        logic         data;
    } sau_cfg_t;

    // Data bits per word for a format code
    function automatic logic [3:0] fmt_bits(input logic [2:0] fmt);
        fmt_bits = fmt[2] ? 4'd8 : 4'd7;
    endfunction

    // Stop bits per word: two for 7E2, 7O2 and 8N2
    function automatic logic [1:0] fmt_stops(input logic [2:0] fmt);
        logic [1:0] n;
        unique case (fmt)
            3'd0, 3'd1, 3'd4: n = 2'd2;
            default:          n = 2'd1;
        endcase
        fmt_stops = n;
    endfunction

    // Word carries a parity bit unless it is 8N2 or 8N1
    function automatic logic fmt_has_par(input logic [2:0] fmt);
        fmt_has_par = (fmt[2:1] != 2'b10);
    endfunction

    // Even parity formats; any other parity phase uses odd
    function automatic logic fmt_even(input logic [2:0] fmt);
        fmt_even = (fmt == 3'd0) || (fmt == 3'd2) || (fmt == 3'd6);
    endfunction

endpackage

/* rtl/sau_if.sv */
// Request channel: one bus access or one bit tick per beat
interface sau_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       rx_bit;

    modport source (output valid, output operation, output write_data, output rx_bit,
                    input ready);
    modport sink   (input valid, input operation, input write_data, input rx_bit,
                    output ready);
endinterface

// Response channel: one result per request beat
interface sau_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic [7:0] read_data;
    logic       rts_line;

    modport source (output valid, output tx_line, output read_data, output rts_line,
                    input ready);
    modport sink   (input valid, input tx_line, input read_data, input rts_line,
                    output ready);
endinterface

// Configuration write channel
interface sau_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sau_core.sv */
module sau_core
    import sau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  sau_item_t   item,
    input  sau_cfg_t    cfg_wr,
    output sau_result_t result
);

    logic [7:0] control_reg,     control_next;
    logic [6:0] status_reg,      status_next;
    logic [7:0] tx_holding_reg,  tx_holding_next;
    logic [7:0] tx_shift_reg,    tx_shift_next;
    sau_phase_t tx_phase_reg,    tx_phase_next;
    logic [3:0] tx_bits_reg,     tx_bits_next;
    logic [1:0] tx_stops_reg,    tx_stops_next;
    logic       tx_par_reg,      tx_par_next;
    logic       tx_break_reg,    tx_break_next;
    logic       tx_level_reg,    tx_level_next;
    logic       rts_reg,         rts_next;
    logic [7:0] rx_holding_reg,  rx_holding_next;
    logic [7:0] rx_shift_reg,    rx_shift_next;
    sau_phase_t rx_phase_reg,    rx_phase_next;
    logic [3:0] rx_bits_reg,     rx_bits_next;
    logic [1:0] rx_stops_reg,    rx_stops_next;
    logic       rx_par_reg,      rx_par_next;
    logic       ovr_pend_reg,    ovr_pend_next;
    logic       dcd_reg;
    logic       cts_reg;

    logic [2:0] fmt;
    logic [3:0] tx_bits_dec;
    logic [3:0] rx_bits_dec;
    logic [1:0] tx_stops_dec;
    logic [1:0] rx_stops_dec;
    logic [7:0] rx_shifted;
    logic [1:0] tx_ctl;
    logic [7:0] rd_data;

    assign fmt          = control_reg[4:2];
    assign tx_bits_dec  = tx_bits_reg - 4'd1;
    assign rx_bits_dec  = rx_bits_reg - 4'd1;
    assign tx_stops_dec = tx_stops_reg - 2'd1;
    assign rx_stops_dec = rx_stops_reg - 2'd1;
    assign rx_shifted   = {item.rx_bit, rx_shift_reg[7:1]};
    assign tx_ctl       = item.write_data[6:5];

    // Next state for one item
    always_comb
    begin
        control_next    = control_reg;
        status_next     = status_reg;
        tx_holding_next = tx_holding_reg;
        tx_shift_next   = tx_shift_reg;
        tx_phase_next   = tx_phase_reg;
        tx_bits_next    = tx_bits_reg;
        tx_stops_next   = tx_stops_reg;
        tx_par_next     = tx_par_reg;
        tx_break_next   = tx_break_reg;
        tx_level_next   = tx_level_reg;
        rts_next        = rts_reg;
        rx_holding_next = rx_holding_reg;
        rx_shift_next   = rx_shift_reg;
        rx_phase_next   = rx_phase_reg;
        rx_bits_next    = rx_bits_reg;
        rx_stops_next   = rx_stops_reg;
        rx_par_next     = rx_par_reg;
        ovr_pend_next   = ovr_pend_reg;
        rd_data         = 8'd0;

        unique case (item.operation)
            OP_TICK:
            begin
                // Transmitter: advance one bit time
                unique case (tx_phase_reg)
                    PH_IDLE:
                    begin
                        if (tx_break_reg)
                        begin
                            tx_level_next = 1'b0;
                        end
                        else if (tx_bits_reg == 4'd0 && !status_reg[ST_TDRE])
                        begin
                            // Pull the waiting byte and send the start bit
                            tx_shift_next         = tx_holding_reg;
                            tx_par_next           = 1'b0;
                            tx_bits_next          = fmt_bits(fmt);
                            tx_stops_next         = fmt_stops(fmt);
                            status_next[ST_TDRE]  = 1'b1;
                            tx_level_next         = 1'b0;
                            tx_phase_next         = PH_DATA;
                        end
                        else if (tx_bits_reg == 4'd0)
                        begin
                            tx_level_next = 1'b1;
                        end
                        else
                        begin
                            tx_level_next = 1'b0;
                            tx_phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        tx_level_next = tx_shift_reg[0];
                        tx_par_next   = tx_par_reg ^ tx_shift_reg[0];
                        tx_shift_next = {1'b0, tx_shift_reg[7:1]};
                        tx_bits_next  = tx_bits_dec;
                        if (tx_bits_dec == 4'd0)
                        begin
                            tx_phase_next = fmt_has_par(fmt) ? PH_PARITY : PH_STOP;
                        end
                    end
                    PH_PARITY:
                    begin
                        tx_level_next = fmt_even(fmt) ? tx_par_reg : ~tx_par_reg;
                        tx_phase_next = PH_STOP;
                    end
                    PH_STOP:
                    begin
                        tx_level_next = 1'b1;
                        tx_stops_next = tx_stops_dec;
                        if (tx_stops_dec == 2'd0)
                        begin
                            tx_phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        tx_phase_next = PH_IDLE;
                    end
                endcase

                // Receiver: sample the line once
                unique case (rx_phase_reg)
                    PH_IDLE:
                    begin
                        if (!item.rx_bit)
                        begin
                            rx_shift_next = 8'd0;
                            rx_par_next   = 1'b0;
                            rx_bits_next  = fmt_bits(fmt);
                            rx_stops_next = fmt_stops(fmt);
                            rx_phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        rx_shift_next = rx_shifted;
                        rx_par_next   = rx_par_reg ^ item.rx_bit;
                        rx_bits_next  = rx_bits_dec;
                        if (rx_bits_dec == 4'd0)
                        begin
                            // Right-align seven-bit words
                            if (!fmt[2])
                            begin
                                rx_shift_next = {1'b0, rx_shifted[7:1]};
                            end
                            if (status_reg[ST_RDRF])
                            begin
                                ovr_pend_next = 1'b1;
                            end
                            rx_phase_next = fmt_has_par(fmt) ? PH_PARITY : PH_STOP;
                        end
                    end
                    PH_PARITY:
                    begin
                        if ((rx_par_reg ^ item.rx_bit) != !fmt_even(fmt))
                        begin
                            status_next[ST_PE] = 1'b1;
                        end
                        rx_phase_next = PH_STOP;
                    end
                    PH_STOP:
                    begin
                        if (item.rx_bit)
                        begin
                            rx_stops_next = rx_stops_dec;
                            if (rx_stops_dec == 2'd0)
                            begin
                                status_next[ST_FE] = 1'b0;
                                if (!status_reg[ST_RDRF])
                                begin
                                    rx_holding_next      = rx_shift_reg;
                                    status_next[ST_RDRF] = 1'b1;
                                end
                                rx_phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            // Low stop bit: framing error, keep the byte unflagged
                            status_next[ST_FE] = 1'b1;
                            rx_holding_next    = rx_shift_reg;
                            rx_phase_next      = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        rx_phase_next = PH_IDLE;
                    end
                endcase
            end
            OP_WR_CTRL:
            begin
                if (item.write_data[1:0] == CTRL_MASTER_RESET)
                begin
                    status_next          = 7'd0;
                    status_next[ST_TDRE] = 1'b1;
                    status_next[ST_DCD]  = dcd_reg;
                    status_next[ST_CTS]  = cts_reg;
                    tx_phase_next        = PH_IDLE;
                    tx_shift_next        = 8'd0;
                    tx_bits_next         = 4'd0;
                    rx_phase_next        = PH_IDLE;
                    rx_shift_next        = 8'd0;
                    rx_bits_next         = 4'd0;
                    ovr_pend_next        = 1'b0;
                end
                tx_break_next = (tx_ctl == TXC_BREAK);
                rts_next      = (tx_ctl == TXC_RTS_HIGH);
                control_next  = item.write_data;
            end
            OP_WR_TXDATA:
            begin
                tx_holding_next      = item.write_data;
                status_next[ST_TDRE] = 1'b0;
                if (tx_phase_reg == PH_IDLE)
                begin
                    // Load straight into the shifter
                    tx_shift_next        = item.write_data;
                    tx_par_next          = 1'b0;
                    tx_bits_next         = fmt_bits(fmt);
                    tx_stops_next        = fmt_stops(fmt);
                    status_next[ST_TDRE] = 1'b1;
                end
            end
            OP_RD_STATUS:
            begin
                rd_data = {1'b0, status_reg};
            end
            OP_RD_RXDATA:
            begin
                rd_data              = rx_holding_reg;
                status_next[ST_RDRF] = 1'b0;
                status_next[ST_PE]   = 1'b0;
                status_next[ST_OVRN] = ovr_pend_reg;
                ovr_pend_next        = 1'b0;
            end
            default:
            begin
                rd_data = 8'd0;
            end
        endcase
    end

    assign result.tx_line   = tx_level_next;
    assign result.read_data = rd_data;
    assign result.rts_line  = rts_next;

    // Hold pin levels from the configuration channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcd_reg <= 1'b0;
            cts_reg <= 1'b0;
        end
        else if (cfg_wr.en)
        begin
            unique case (cfg_wr.index)
                CFG_DCD: dcd_reg <= cfg_wr.data;
                CFG_CTS: cts_reg <= cfg_wr.data;
                default: dcd_reg <= dcd_reg;
            endcase
        end
    end

    // Advance the UART state on each stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= 8'd0;
            status_reg     <= 7'd1 << ST_TDRE;
            tx_holding_reg <= 8'd0;
            tx_shift_reg   <= 8'd0;
            tx_phase_reg   <= PH_IDLE;
            tx_bits_reg    <= 4'd0;
            tx_stops_reg   <= 2'd0;
            tx_par_reg     <= 1'b0;
            tx_break_reg   <= 1'b0;
            tx_level_reg   <= 1'b1;
            rts_reg        <= 1'b0;
            rx_holding_reg <= 8'd0;
            rx_shift_reg   <= 8'd0;
            rx_phase_reg   <= PH_IDLE;
            rx_bits_reg    <= 4'd0;
            rx_stops_reg   <= 2'd0;
            rx_par_reg     <= 1'b0;
            ovr_pend_reg   <= 1'b0;
        end
        else if (step)
        begin
            control_reg    <= control_next;
            status_reg     <= status_next;
            tx_holding_reg <= tx_holding_next;
            tx_shift_reg   <= tx_shift_next;
            tx_phase_reg   <= tx_phase_next;
            tx_bits_reg    <= tx_bits_next;
            tx_stops_reg   <= tx_stops_next;
            tx_par_reg     <= tx_par_next;
            tx_break_reg   <= tx_break_next;
            tx_level_reg   <= tx_level_next;
            rts_reg        <= rts_next;
            rx_holding_reg <= rx_holding_next;
            rx_shift_reg   <= rx_shift_next;
            rx_phase_reg   <= rx_phase_next;
            rx_bits_reg    <= rx_bits_next;
            rx_stops_reg   <= rx_stops_next;
            rx_par_reg     <= rx_par_next;
            ovr_pend_reg   <= ovr_pend_next;
        end
    end

endmodule

/* rtl/serial_acia_uart_top.sv */
// Four-register asynchronous serial interface, one bus access or bit tick per beat.
// Channels: req carries operation, write_data and rx_bit; rsp returns tx_line,
// read_data and rts_line, exactly one rsp beat per req beat, in order.
// cfg writes the DCD (index 0) and CTS (index 1) pin levels; they reach the
// status register at the next master reset. cfg is always ready.
// A req beat is captured in an input register, and the UART state is updated as
// it moves to the output register, which holds the rsp beat until it is taken.
// Throughput: one beat per cycle while rsp is taken; the whole state update is a
// single pass of logic between the two registers.
// Stall: when rsp is not taken, the output holds its beat and the input
// register keeps one more; req.ready drops only when both are full.
// Reset: rst_n clears the valid flags of both registers and puts the UART in its
// post-reset state: control zero, transmitter empty, line idle high, RTS low.
`include "serial_acia_uart_top_defines.svh"

module serial_acia_uart_top
    import sau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    sau_req_if.sink   req,
    sau_rsp_if.source rsp,
    sau_cfg_if.sink   cfg
);

    sau_item_t   item_reg;
    logic        item_vld_reg;
    sau_result_t res_reg;
    logic        res_vld_reg;
    sau_result_t res_next;
    sau_cfg_t    cfg_wr;
    logic        advance;
    logic        step;

    assign advance = !res_vld_reg || rsp.ready;
    assign step    = item_vld_reg && advance;

    assign req.ready = !item_vld_reg || advance;
    assign cfg.ready = 1'b1;

    assign cfg_wr.en    = cfg.valid;
    assign cfg_wr.index = sau_cfg_idx_t'(cfg.index);
    assign cfg_wr.data  = cfg.data;

    sau_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg_wr (cfg_wr),
        .result (res_next)
    );

    // Capture a request beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.operation  <= req.operation;
            item_reg.write_data <= req.write_data;
            item_reg.rx_bit     <= req.rx_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            item_vld_reg <= req.valid;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= item_vld_reg;
        end
    end

    assign rsp.valid     = res_vld_reg;
    assign rsp.tx_line   = res_reg.tx_line;
    assign rsp.read_data = res_reg.read_data;
    assign rsp.rts_line  = res_reg.rts_line;

    // Checks
    `SAU_ASSERT_NEXT(a_req_captured, req.valid && req.ready, item_vld_reg,
        "accepted request beat not held in input register")
    `SAU_ASSERT_NEXT(a_step_gives_result, step, res_vld_reg,
        "stepped item produced no result beat")
    `SAU_ASSERT_NOW(a_backpressure_source, !req.ready,
        item_vld_reg && res_vld_reg && !rsp.ready,
        "request stalled while the pipeline has room")

endmodule
